// File: design/pkcm_pkg.sv
// Shared types, command codes and constants of the polygon keepout cell marker.
`default_nettype none

package pkcm_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int COORD_FIELD_W = 32;
   localparam int COST_W        = 8;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SHORT = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KEEPOUT_COST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_OK     = 2'd2;

   // Highest keepout cost; larger writes saturate to it.
   localparam logic [COST_W-1:0] KEEPOUT_MAX = 8'd254;

   // A closed polygon needs at least this many vertices to be kept.
   localparam int MIN_POLY_VERTS = 3;

   typedef struct packed {
      logic [CMD_W-1:0]                cmd;
      logic signed [COORD_FIELD_W-1:0] coord_x;
      logic signed [COORD_FIELD_W-1:0] coord_y;
      logic                            closes_polygon;
      logic [COST_W-1:0]               prior_cost;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0]   new_cost;
      logic                inside_res;
      logic                changed;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic qry_start;
      logic rd_en;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_query;
      logic pipe_busy;
   } ctl_stat_type;

endpackage

`default_nettype wire

// File: design/pkcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pkcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/pkcm_ctrl.sv
// Controller state machine: transaction acceptance, vertex read sequencing and response hand-off.
`default_nettype none

module pkcm_ctrl #(
   parameter int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int NW = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire pkcm_pkg::ctl_stat_type stat,
   input  wire logic [NW-1:0]          table_end,
   output pkcm_pkg::ctl_cmd_type       ctl,
   output logic      [AW-1:0]          rd_addr
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [NW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      ctl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               if (stat.req_is_query) begin
                  ctl.qry_start = 1'b1;
                  rd_cnt_in     = '0;
                  state_in      = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            // One vertex read per cycle over all closed polygons.
            if (rd_cnt_ff == table_end) begin
               state_in = ST_DRAIN;
            end else begin
               ctl.rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + NW'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctl.commit | (rsp_valid_ff & ~rsp_ready);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = rd_cnt_ff[AW-1:0];

endmodule

`default_nettype wire

// File: design/pkcm_datapath.sv
// Datapath: vertex table, configuration registers, edge crossing pipeline and response register.
`default_nettype none

module pkcm_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 32,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int NW = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pkcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pkcm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire pkcm_pkg::req_type                    req_data,
   input  wire pkcm_pkg::ctl_cmd_type                ctl,
   input  wire logic [AW-1:0]                        rd_addr,
   output pkcm_pkg::ctl_stat_type                    stat,
   output logic      [NW-1:0]                        table_end,
   output pkcm_pkg::rsp_type                         rsp_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = COORD_WIDTH + 1;
   localparam int VW   = 2 * COORD_WIDTH + 1;
   localparam int LO_W = (COORD_WIDTH + 1) / 2;
   localparam int HI_W = COORD_WIDTH - LO_W;
   localparam int PW   = 2 * COORD_WIDTH;
   localparam int LL_W = 2 * LO_W;
   localparam int HH_W = 2 * HI_W;

   // ---------------------------------------------------------------
   // Configuration registers.
   logic [pkcm_pkg::COST_W-1:0] mark_cost_ff;
   logic                        enable_ff;
   logic                        frame_ok_ff;
   logic [pkcm_pkg::COST_W-1:0] mark_cost_in;

   assign mark_cost_in = (csr_wdata > pkcm_pkg::KEEPOUT_MAX) ?
                         pkcm_pkg::KEEPOUT_MAX : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_cost_ff <= pkcm_pkg::KEEPOUT_MAX;
         enable_ff    <= 1'b1;
         frame_ok_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pkcm_pkg::CSR_KEEPOUT_COST: mark_cost_ff <= mark_cost_in;
            pkcm_pkg::CSR_ENABLE:       enable_ff    <= csr_wdata[0];
            pkcm_pkg::CSR_FRAME_OK:     frame_ok_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Captured request transaction.
   logic [pkcm_pkg::CMD_W-1:0]  cmd_ff;
   logic signed [CW-1:0]        px_ff, py_ff;
   logic                        closes_ff;
   logic [pkcm_pkg::COST_W-1:0] prior_cost_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff        <= req_data.cmd;
         px_ff         <= CW'(req_data.coord_x);
         py_ff         <= CW'(req_data.coord_y);
         closes_ff     <= req_data.closes_polygon;
         prior_cost_ff <= req_data.prior_cost;
      end
   end

   assign stat.req_is_query = (req_data.cmd == pkcm_pkg::CMD_QUERY);

   // ---------------------------------------------------------------
   // Table bookkeeping: fill count and start of the open polygon.
   logic [NW-1:0]                 count_ff, count_in, ops_ff, ops_in, cnt_inc;
   logic                          table_full;
   logic [pkcm_pkg::STATUS_W-1:0] status_res;
   logic                          ram_wr_en;
   logic [VW-1:0]                 ram_wr_data, ram_rd_data;

   assign cnt_inc    = count_ff + NW'(1);
   assign table_full = (count_ff == NW'(MAX_VERTICES));

   always_comb begin
      count_in   = count_ff;
      ops_in     = ops_ff;
      status_res = pkcm_pkg::STAT_OK;
      if (ctl.commit) begin
         unique case (cmd_ff)
            pkcm_pkg::CMD_CLEAR: begin
               count_in = '0;
               ops_in   = '0;
            end
            pkcm_pkg::CMD_APPEND: begin
               if (table_full) begin
                  status_res = pkcm_pkg::STAT_FULL;
               end else if (closes_ff) begin
                  // A polygon too short to enclose anything is dropped again.
                  if ((cnt_inc - ops_ff) < NW'(pkcm_pkg::MIN_POLY_VERTS)) begin
                     count_in   = ops_ff;
                     status_res = pkcm_pkg::STAT_SHORT;
                  end else begin
                     count_in = cnt_inc;
                     ops_in   = cnt_inc;
                  end
               end else begin
                  count_in = cnt_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ops_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ops_ff   <= ops_in;
      end
   end

   assign table_end   = ops_ff;
   assign ram_wr_en   = ctl.commit && (cmd_ff == pkcm_pkg::CMD_APPEND) && !table_full;
   assign ram_wr_data = {closes_ff, py_ff, px_ff};

   // Vertex table: close mark, y and x in one word.
   pkcm_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Edge formation from the vertex stream. The closing edge of a polygon is
   // issued in the slot of the next polygon's first vertex, which has no edge.
   logic                 rd_valid_ff, is_first_ff, pending_ff;
   logic signed [CW-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic                 v_mark;
   logic signed [CW-1:0] v_x, v_y;
   logic                 edge_valid, edge_last;
   logic signed [CW-1:0] edge_xi, edge_yi, edge_xj, edge_yj;

   assign v_mark = ram_rd_data[VW-1];
   assign v_y    = ram_rd_data[2*CW-1:CW];
   assign v_x    = ram_rd_data[CW-1:0];

   always_comb begin
      edge_valid = pending_ff || (rd_valid_ff && !is_first_ff);
      if (pending_ff) begin
         edge_last = 1'b1;
         edge_xi   = prev_x_ff;
         edge_yi   = prev_y_ff;
         edge_xj   = first_x_ff;
         edge_yj   = first_y_ff;
      end else begin
         edge_last = 1'b0;
         edge_xi   = v_x;
         edge_yi   = v_y;
         edge_xj   = prev_x_ff;
         edge_yj   = prev_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.qry_start) begin
         is_first_ff <= 1'b1;
         pending_ff  <= 1'b0;
      end else begin
         pending_ff <= rd_valid_ff && v_mark;
         if (rd_valid_ff) begin
            is_first_ff <= v_mark;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prev_x_ff <= v_x;
         prev_y_ff <= v_y;
         if (is_first_ff) begin
            first_x_ff <= v_x;
            first_y_ff <= v_y;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage A: edge end points.
   logic                 a_valid_ff, a_last_ff;
   logic signed [CW-1:0] a_xi_ff, a_yi_ff, a_xj_ff, a_yj_ff;

   always_ff @(posedge clock) begin
      a_last_ff <= edge_last;
      a_xi_ff   <= edge_xi;
      a_yi_ff   <= edge_yi;
      a_xj_ff   <= edge_xj;
      a_yj_ff   <= edge_yj;
   end

   // Stage B: straddle test and differences.
   logic                 b_valid_ff, b_last_ff, b_cond_ff, b_cond_in;
   logic signed [DW-1:0] b_a_ff, b_c_ff, b_dy_ff, b_t_ff;
   logic signed [DW-1:0] b_a_in, b_c_in, b_dy_in, b_t_in;

   always_comb begin
      b_cond_in = (a_yi_ff != a_yj_ff) &&
                  (((a_yi_ff <= py_ff) && (py_ff < a_yj_ff)) ||
                   ((a_yj_ff <= py_ff) && (py_ff < a_yi_ff)));
      b_a_in  = DW'(px_ff)   - DW'(a_xi_ff);
      b_c_in  = DW'(a_xj_ff) - DW'(a_xi_ff);
      b_dy_in = DW'(a_yj_ff) - DW'(a_yi_ff);
      b_t_in  = DW'(py_ff)   - DW'(a_yi_ff);
   end

   always_ff @(posedge clock) begin
      b_last_ff <= a_last_ff;
      b_cond_ff <= b_cond_in;
      b_a_ff    <= b_a_in;
      b_c_ff    <= b_c_in;
      b_dy_ff   <= b_dy_in;
      b_t_ff    <= b_t_in;
   end

   // Stage C: sign and magnitude of both products. The sign of dy is folded
   // into the sign of t so that the dy factor is always positive.
   logic          c_valid_ff, c_last_ff, c_cond_ff, c_s1_ff, c_s2_ff;
   logic [CW-1:0] c_ma_ff, c_mdy_ff, c_mc_ff, c_mt_ff;
   logic [CW-1:0] c_ma_in, c_mdy_in, c_mc_in, c_mt_in;

   always_comb begin
      c_ma_in  = CW'(b_a_ff[CW]  ? -b_a_ff  : b_a_ff);
      c_mdy_in = CW'(b_dy_ff[CW] ? -b_dy_ff : b_dy_ff);
      c_mc_in  = CW'(b_c_ff[CW]  ? -b_c_ff  : b_c_ff);
      c_mt_in  = CW'(b_t_ff[CW]  ? -b_t_ff  : b_t_ff);
   end

   always_ff @(posedge clock) begin
      c_last_ff <= b_last_ff;
      c_cond_ff <= b_cond_ff;
      c_s1_ff   <= b_a_ff[CW];
      c_s2_ff   <= b_c_ff[CW] ^ b_t_ff[CW] ^ b_dy_ff[CW];
      c_ma_ff   <= c_ma_in;
      c_mdy_ff  <= c_mdy_in;
      c_mc_ff   <= c_mc_in;
      c_mt_ff   <= c_mt_in;
   end

   // Stage D: half-width partial products of both magnitudes.
   logic            d_valid_ff, d_last_ff, d_cond_ff, d_s1_ff, d_s2_ff;
   logic [LL_W-1:0] d_p1_ll_ff, d_p2_ll_ff;
   logic [CW-1:0]   d_p1_lh_ff, d_p1_hl_ff, d_p2_lh_ff, d_p2_hl_ff;
   logic [HH_W-1:0] d_p1_hh_ff, d_p2_hh_ff;

   always_ff @(posedge clock) begin
      d_last_ff  <= c_last_ff;
      d_cond_ff  <= c_cond_ff;
      d_s1_ff    <= c_s1_ff;
      d_s2_ff    <= c_s2_ff;
      d_p1_ll_ff <= LL_W'(c_ma_ff[LO_W-1:0]) * LL_W'(c_mdy_ff[LO_W-1:0]);
      d_p1_lh_ff <= CW'(c_ma_ff[LO_W-1:0]) * CW'(c_mdy_ff[CW-1:LO_W]);
      d_p1_hl_ff <= CW'(c_ma_ff[CW-1:LO_W]) * CW'(c_mdy_ff[LO_W-1:0]);
      d_p1_hh_ff <= HH_W'(c_ma_ff[CW-1:LO_W]) * HH_W'(c_mdy_ff[CW-1:LO_W]);
      d_p2_ll_ff <= LL_W'(c_mc_ff[LO_W-1:0]) * LL_W'(c_mt_ff[LO_W-1:0]);
      d_p2_lh_ff <= CW'(c_mc_ff[LO_W-1:0]) * CW'(c_mt_ff[CW-1:LO_W]);
      d_p2_hl_ff <= CW'(c_mc_ff[CW-1:LO_W]) * CW'(c_mt_ff[LO_W-1:0]);
      d_p2_hh_ff <= HH_W'(c_mc_ff[CW-1:LO_W]) * HH_W'(c_mt_ff[CW-1:LO_W]);
   end

   // Stage E: full product magnitudes.
   logic          e_valid_ff, e_last_ff, e_cond_ff, e_s1_ff, e_s2_ff;
   logic [PW-1:0] e_m1_ff, e_m2_ff, e_m1_in, e_m2_in;

   always_comb begin
      e_m1_in = (PW'(d_p1_hh_ff) << LL_W) + (PW'(d_p1_lh_ff) << LO_W) +
                (PW'(d_p1_hl_ff) << LO_W) + PW'(d_p1_ll_ff);
      e_m2_in = (PW'(d_p2_hh_ff) << LL_W) + (PW'(d_p2_lh_ff) << LO_W) +
                (PW'(d_p2_hl_ff) << LO_W) + PW'(d_p2_ll_ff);
   end

   always_ff @(posedge clock) begin
      e_last_ff <= d_last_ff;
      e_cond_ff <= d_cond_ff;
      e_s1_ff   <= d_s1_ff;
      e_s2_ff   <= d_s2_ff;
      e_m1_ff   <= e_m1_in;
      e_m2_ff   <= e_m2_in;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= edge_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // Signed compare of the two products in sign-magnitude form. A zero
   // magnitude may carry either sign, which every arm tolerates.
   logic prod_less, edge_hit;

   always_comb begin
      unique case ({e_s1_ff, e_s2_ff})
         2'b10: prod_less = (e_m1_ff != '0) || (e_m2_ff != '0);
         2'b01: prod_less = 1'b0;
         2'b00: prod_less = (e_m1_ff < e_m2_ff);
         2'b11: prod_less = (e_m1_ff > e_m2_ff);
      endcase
   end

   assign edge_hit = e_cond_ff && prod_less;

   // Even-odd parity per polygon, folded into the inside flag at its end.
   logic odd_ff, odd_in, any_ff, any_in;

   always_comb begin
      odd_in = odd_ff;
      any_in = any_ff;
      if (e_valid_ff) begin
         if (e_last_ff) begin
            any_in = any_ff | (odd_ff ^ edge_hit);
            odd_in = 1'b0;
         end else begin
            odd_in = odd_ff ^ edge_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.qry_start) begin
         odd_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         odd_ff <= odd_in;
         any_ff <= any_in;
      end
   end

   assign stat.pipe_busy = rd_valid_ff | pending_ff | a_valid_ff | b_valid_ff |
                           c_valid_ff | d_valid_ff | e_valid_ff;

   // ---------------------------------------------------------------
   // Response register.
   logic                        is_query, in_poly, raise;
   logic [pkcm_pkg::COST_W-1:0] new_cost;
   pkcm_pkg::rsp_type           rsp_ff, rsp_in;

   always_comb begin
      is_query = (cmd_ff == pkcm_pkg::CMD_QUERY);
      in_poly  = is_query && any_ff;
      raise    = in_poly && enable_ff && frame_ok_ff && (prior_cost_ff < mark_cost_ff);
      new_cost = raise ? mark_cost_ff : prior_cost_ff;
      rsp_in.new_cost   = new_cost;
      rsp_in.inside_res = in_poly;
      rsp_in.changed    = (new_cost != prior_cost_ff);
      rsp_in.status     = status_res;
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: design/polygon_keepout_cell_marker.sv
// Top level of the polygon keepout cell marker: controller, datapath and checks.
//
// Usage: the req channel carries one command per transaction: clear the
// vertex table, append one vertex (closes_polygon ends the polygon), or
// query a cell centre with its old cost. Each request transaction yields
// exactly one rsp transaction with the new cost, inside flag, changed flag
// and status. The csr port writes the keepout cost, the enable bit and the
// frame match bit; the user must do so only while the block is idle, which
// the block itself does not enforce. Writes take effect at once. Clear and
// append go from acceptance through the finish state to the response
// register. A query reads the N vertices in closed polygons: the single read
// port of the vertex RAM delivers one vertex a cycle, and one edge a cycle
// runs through a five-stage crossing pipeline, which drains before the next
// item may enter. The block works on one request at a time, but accepts the
// next request while the previous response still waits in the output
// register; a stalled receiver holds only the finished result and delays
// the next hand-off. Synchronous reset empties the table, restores the
// register defaults and drops any pending response; no clearing pass is needed.
`default_nettype none

module polygon_keepout_cell_marker #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire pkcm_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output pkcm_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [pkcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pkcm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   pkcm_pkg::ctl_cmd_type  ctl;
   pkcm_pkg::ctl_stat_type stat;
   logic [AW-1:0]          rd_addr;
   logic [NW-1:0]          table_end;

   pkcm_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .table_end (table_end),
      .ctl       (ctl),
      .rd_addr   (rd_addr)
   );

   pkcm_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .stat      (stat),
      .table_end (table_end),
      .rsp_data  (rsp_data)
   );

   // Reads stay inside the closed polygons of the table.
   a_rd_in_table: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> (NW'(rd_addr) < table_end))
      else $error("vertex read beyond the closed polygons");

   // A response is loaded only after every edge of a query has drained.
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !stat.pipe_busy)
      else $error("response loaded while edges are still in flight");

   // One request at a time: the cycle after acceptance the block is busy.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted back to back");

   // A response appears only through a commit of the controller.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.commit))
      else $error("response valid without a commit");

endmodule

`default_nettype wire
